[hw/rtl/pmst_pkg.sv]
// pmst_pkg: shared constants, codes and controller/datapath interface types
// for the prim minimum spanning tree block; depends on nothing
package pmst_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int WEIGHT_BITS_DEF  = 16;
    localparam int VERTEX_CAP       = 16;

    localparam int IDX_W      = 4;
    localparam int WFIELD_W   = 16;
    localparam int SUM_W      = 20;
    localparam int VC_W       = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 48;

    localparam logic [VC_W-1:0] VC_RESET         = 5'd16;
    localparam logic            REG_VERTEX_COUNT = 1'b0;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed
    {
        logic start;
        logic scan;
        logic commit;
    } cmd_t;

    typedef struct packed
    {
        logic scan_done;
        logic found;
        logic final_edge;
        logic out_free;
    } status_t;

endpackage

[hw/rtl/pmst_ctrl.sv]
// pmst_ctrl: run sequencer, idle / scan / emit
// depends on pmst_pkg for state, command and status types
module pmst_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start_req,
    input  pmst_pkg::status_t st,
    output pmst_pkg::cmd_t    cmd,
    output logic              idle
);
    import pmst_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_req)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (st.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    if (!st.found || st.final_edge)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        idle = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                idle      = 1'b1;
                cmd.start = start_req;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.commit = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[hw/rtl/pmst_dpath.sv]
// pmst_dpath: weight memory, link tables, relax-and-select scan, result register
// depends on pmst_pkg; driven by pmst_ctrl commands
module pmst_dpath
#(
    parameter int MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = pmst_pkg::WEIGHT_BITS_DEF,
    parameter int CW           = 5
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pmst_pkg::cmd_t                cmd,
    output pmst_pkg::status_t             st,
    input  logic                          load_en,
    input  logic [pmst_pkg::IDX_W-1:0]    load_row,
    input  logic [pmst_pkg::IDX_W-1:0]    load_col,
    input  logic [pmst_pkg::WFIELD_W-1:0] load_weight,
    input  logic [CW-1:0]                 n,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [pmst_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import pmst_pkg::*;

    localparam int ROWS  = (MAX_VERTICES < VERTEX_CAP) ? MAX_VERTICES : VERTEX_CAP;
    localparam int VW    = $clog2(ROWS);
    localparam int DEPTH = ROWS * ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int WB    = WEIGHT_BITS;
    localparam int LW    = WB + 1;
    localparam int ADDW  = ((WB > SUM_W) ? WB : SUM_W) + 1;

    localparam logic [LW-1:0]    LINK_INF = {1'b1, {WB{1'b0}}};
    localparam logic [SUM_W-1:0] SUM_MAX  = '1;

    logic [WB-1:0] mem [DEPTH];
    logic [WB-1:0] rdata_reg;

    logic [31:0]   load_w32;
    logic [WB-1:0] load_w;
    logic          row_ok;
    logic          col_ok;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          issue;

    logic [CW-1:0]   issue_v_reg;
    logic            proc_valid_reg;
    logic [VW-1:0]   proc_v_reg;
    logic [ROWS-1:0] in_tree_reg;
    logic [LW-1:0]   best_w_reg [ROWS];
    logic [VW-1:0]   best_s_reg [ROWS];
    logic [VW-1:0]   u_reg;
    logic            found_reg;
    logic [VW-1:0]   min_v_reg;
    logic [LW-1:0]   min_w_reg;
    logic [VW-1:0]   min_s_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CW-1:0]   count_reg;

    logic                m_tvalid_reg;
    logic [IDX_W-1:0]    out_from_reg;
    logic [IDX_W-1:0]    out_to_reg;
    logic [WFIELD_W-1:0] out_ew_reg;
    logic [SUM_W-1:0]    out_total_reg;
    logic                out_disc_reg;
    logic                out_last_reg;

    logic [LW-1:0]    cur_w;
    logic [VW-1:0]    cur_s;
    logic [LW-1:0]    w_ext;
    logic             upd;
    logic [LW-1:0]    new_w;
    logic [VW-1:0]    new_s;
    logic             take;
    logic [ADDW-1:0]  sum_ext;
    logic [SUM_W-1:0] sum_next;
    logic [31:0]      ew32;
    logic             final_edge;

    assign load_w32 = 32'(load_weight);
    assign load_w   = load_w32[WB-1:0];
    assign row_ok   = VC_W'(load_row) < VC_W'(ROWS);
    assign col_ok   = VC_W'(load_col) < VC_W'(ROWS);
    assign wr_addr  = AW'(load_row[VW-1:0]) * AW'(ROWS) + AW'(load_col[VW-1:0]);
    assign issue    = cmd.scan && (issue_v_reg < n);
    assign rd_addr  = AW'(u_reg) * AW'(ROWS) + AW'(issue_v_reg[VW-1:0]);

    always_ff @(posedge clk)
    begin
        if (load_en && row_ok && col_ok)
        begin
            mem[wr_addr] <= load_w;
        end
        rdata_reg <= mem[rd_addr];
    end

    // relax the scanned vertex against the new tree vertex, then keep the running minimum
    always_comb
    begin
        cur_w = best_w_reg[proc_v_reg];
        cur_s = best_s_reg[proc_v_reg];
        w_ext = {1'b0, rdata_reg};
        upd   = proc_valid_reg && !in_tree_reg[proc_v_reg] && (rdata_reg != '0)
                && ((w_ext < cur_w) || ((w_ext == cur_w) && (u_reg < cur_s)));
        new_w = upd ? w_ext : cur_w;
        new_s = upd ? u_reg : cur_s;
        take  = proc_valid_reg && !in_tree_reg[proc_v_reg] && !new_w[WB]
                && (!found_reg || (new_w < min_w_reg));
    end

    assign sum_ext    = ADDW'(sum_reg) + ADDW'(min_w_reg[WB-1:0]);
    assign sum_next   = (sum_ext > ADDW'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];
    assign ew32       = 32'(min_w_reg[WB-1:0]);
    assign final_edge = CW'(count_reg + 1'b1) == CW'(n - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_v_reg    <= '0;
            proc_valid_reg <= 1'b0;
            proc_v_reg     <= '0;
            in_tree_reg    <= '0;
            for (int i = 0; i < ROWS; i++)
            begin
                best_w_reg[i] <= LINK_INF;
                best_s_reg[i] <= '0;
            end
            u_reg     <= '0;
            found_reg <= 1'b0;
            min_v_reg <= '0;
            min_w_reg <= '0;
            min_s_reg <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.start)
        begin
            issue_v_reg    <= '0;
            proc_valid_reg <= 1'b0;
            in_tree_reg    <= ROWS'(1);
            for (int i = 0; i < ROWS; i++)
            begin
                best_w_reg[i] <= LINK_INF;
                best_s_reg[i] <= '0;
            end
            u_reg     <= '0;
            found_reg <= 1'b0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            issue_v_reg    <= '0;
            proc_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            if (found_reg)
            begin
                in_tree_reg[min_v_reg] <= 1'b1;
                sum_reg                <= sum_next;
                count_reg              <= CW'(count_reg + 1'b1);
                u_reg                  <= min_v_reg;
            end
        end
        else
        begin
            proc_valid_reg <= issue;
            proc_v_reg     <= issue_v_reg[VW-1:0];
            if (issue)
            begin
                issue_v_reg <= CW'(issue_v_reg + 1'b1);
            end
            if (upd)
            begin
                best_w_reg[proc_v_reg] <= new_w;
                best_s_reg[proc_v_reg] <= new_s;
            end
            if (take)
            begin
                found_reg <= 1'b1;
                min_v_reg <= proc_v_reg;
                min_w_reg <= new_w;
                min_s_reg <= new_s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (found_reg)
            begin
                out_from_reg  <= IDX_W'(min_s_reg);
                out_to_reg    <= IDX_W'(min_v_reg);
                out_ew_reg    <= ew32[WFIELD_W-1:0];
                out_total_reg <= sum_next;
                out_disc_reg  <= 1'b0;
                out_last_reg  <= final_edge;
            end
            else
            begin
                out_from_reg  <= '0;
                out_to_reg    <= '0;
                out_ew_reg    <= '0;
                out_total_reg <= sum_reg;
                out_disc_reg  <= 1'b1;
                out_last_reg  <= 1'b1;
            end
        end
    end

    assign st.scan_done  = proc_valid_reg && (CW'(proc_v_reg) == CW'(n - 1'b1));
    assign st.found      = found_reg;
    assign st.final_edge = final_edge;
    assign st.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, out_total_reg, out_ew_reg, out_to_reg, out_from_reg};
    assign m_tuser  = out_disc_reg;
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_commit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten before it was taken");

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid_reg)
        else $error("committed result not presented");

    a_one_vertex_per_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && found_reg) |=>
            ($countones(in_tree_reg) == $past($countones(in_tree_reg)) + 1))
        else $error("chosen vertex was already in the tree");
`endif

endmodule

[hw/rtl/prim_minimum_spanning_tree.sv]
// prim_minimum_spanning_tree: top level, config register and channel glue
// depends on pmst_pkg, pmst_ctrl and pmst_dpath
//
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   tdata row,col,weight; tuser op
//  m_*       out        m_tvalid/m_tready   tdata from,to,edge,total; tuser disc; tlast
//  apb       in         psel/penable        vertex_count at byte address 0
//
//  a weight load is accepted back to back while the block is idle
//  a start runs up to (n - 1) rounds, each scanning one row entry per cycle
//  through the single read port of the weight memory
//  reset clears control and link state; the weight memory keeps no reset
//  a round waits in its emit step while the result register is still full
module prim_minimum_spanning_tree
#(
    parameter int MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = pmst_pkg::WEIGHT_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pmst_pkg::S_DATA_W-1:0]   s_tdata,   // row[3:0], col[7:4], weight[23:8]
    input  logic                            s_tuser,   // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pmst_pkg::M_DATA_W-1:0]   m_tdata,   // from[3:0], to[7:4], edge[23:8], total[43:24]
    output logic                            m_tuser,   // disconnected
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pmst_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pmst_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pmst_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import pmst_pkg::*;

    localparam int ROWS = (MAX_VERTICES < VERTEX_CAP) ? MAX_VERTICES : VERTEX_CAP;
    localparam int CW   = $clog2(ROWS) + 1;

    logic [VC_W-1:0] vc_reg;
    logic [VC_W-1:0] n_full;
    logic [CW-1:0]   n;
    logic            idle;
    logic            start_req;
    logic            load_en;
    cmd_t            cmd;
    status_t         st;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= VC_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_VERTEX_COUNT))
        begin
            vc_reg <= pwdata[VC_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? APB_DATA_W'(vc_reg) : '0;

    always_comb
    begin
        priority if (vc_reg < VC_W'(2))
        begin
            n_full = VC_W'(2);
        end
        else if (vc_reg > VC_W'(ROWS))
        begin
            n_full = VC_W'(ROWS);
        end
        else
        begin
            n_full = vc_reg;
        end
    end

    assign n         = n_full[CW-1:0];
    assign s_tready  = idle;
    assign start_req = s_tvalid && (op_t'(s_tuser) == OP_START);
    assign load_en   = s_tvalid && s_tready && (op_t'(s_tuser) == OP_LOAD);

    pmst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start_req (start_req),
        .st        (st),
        .cmd       (cmd),
        .idle      (idle)
    );

    pmst_dpath
    #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS),
        .CW           (CW)
    )
    u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .load_en     (load_en),
        .load_row    (s_tdata[3:0]),
        .load_col    (s_tdata[7:4]),
        .load_weight (s_tdata[23:8]),
        .n           (n),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for prim_minimum_spanning_tree, loads weight matrices over the
// input stream, starts tree runs and checks every emitted edge against its own predictor
// depends on pmst_pkg and the rtl of the block only
module tb;
    import pmst_pkg::*;

    localparam int DRAIN      = 40;
    localparam int STALL_MAX  = 4000;
    localparam int HOLD_LEN   = 400;
    localparam int RAND_ITEMS = 110;
    localparam int SUM_MAX    = (1 << SUM_W) - 1;
    localparam int TO_LSB     = IDX_W;
    localparam int WT_LSB     = 2 * IDX_W;
    localparam int SUM_LSB    = WT_LSB + WFIELD_W;
    localparam int PAD_LSB    = SUM_LSB + SUM_W;
    localparam logic [APB_ADDR_W-1:0] VC_ADDR = APB_ADDR_W'(4 * int'(REG_VERTEX_COUNT));

    typedef struct packed
    {
        logic [IDX_W-1:0]    from_v;
        logic [IDX_W-1:0]    to_v;
        logic [WFIELD_W-1:0] wt;
        logic [SUM_W-1:0]    total;
        logic                disc;
        logic                tail;
    } tree_edge_t;

    class span_tree_check;
        logic [WFIELD_W-1:0] weights [MAX_VERTICES_DEF][MAX_VERTICES_DEF];
        logic [VC_W-1:0]     vcount;
        bit                  in_tree [MAX_VERTICES_DEF];
        logic [WFIELD_W:0]   link_w [MAX_VERTICES_DEF];
        int                  link_src [MAX_VERTICES_DEF];
        tree_edge_t          edges_due [$];
        int                  mismatches;
        int                  edges_checked;
        int                  runs_started;
        int                  disc_runs;

        function new();
            vcount        = VC_RESET;
            mismatches    = 0;
            edges_checked = 0;
            runs_started  = 0;
            disc_runs     = 0;
        endfunction

        task report(string what, logic [M_DATA_W-1:0] got, logic [M_DATA_W-1:0] want);
            $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
            mismatches++;
        endtask

        function void relax_links(int u, int n);
            for (int v = 0; v < n; v++)
            begin
                if (!in_tree[v] && weights[u][v] != '0 &&
                    (weights[u][v] < link_w[v] ||
                     (weights[u][v] == link_w[v] && u < link_src[v])))
                begin
                    link_w[v]   = {1'b0, weights[u][v]};
                    link_src[v] = u;
                end
            end
        endfunction

        function void grow_tree();
            int n;
            int chosen;
            int pick;
            int sum;
            bit found;
            n = (vcount < 2) ? 2 : ((vcount > VERTEX_CAP) ? VERTEX_CAP : int'(vcount));
            for (int i = 0; i < MAX_VERTICES_DEF; i++)
            begin
                in_tree[i]  = 1'b0;
                link_w[i]   = {1'b1, {WFIELD_W{1'b0}}};
                link_src[i] = 0;
            end
            sum    = 0;
            chosen = 0;
            runs_started++;
            in_tree[0] = 1'b1;
            relax_links(0, n);
            while (chosen < n - 1)
            begin
                found = 1'b0;
                pick  = 0;
                for (int v = 0; v < n; v++)
                begin
                    if (!in_tree[v] && !link_w[v][WFIELD_W] &&
                        (!found || link_w[v] < link_w[pick]))
                    begin
                        pick  = v;
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    edges_due.push_back('{from_v: '0, to_v: '0, wt: '0,
                                          total: SUM_W'(sum), disc: 1'b1, tail: 1'b1});
                    disc_runs++;
                    break;
                end
                in_tree[pick] = 1'b1;
                sum = sum + int'(link_w[pick]);
                if (sum > SUM_MAX)
                    sum = SUM_MAX;
                chosen++;
                edges_due.push_back('{from_v: IDX_W'(link_src[pick]), to_v: IDX_W'(pick),
                                      wt: link_w[pick][WFIELD_W-1:0], total: SUM_W'(sum),
                                      disc: 1'b0, tail: 1'(chosen == n - 1)});
                relax_links(pick, n);
            end
        endfunction

        function void note_item(op_t op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                logic [WFIELD_W-1:0] wt);
            if (op == OP_START)
                grow_tree();
            else
                weights[row][col] = wt;
        endfunction

        task check_edge(logic [M_DATA_W-1:0] data, logic disc, logic tail);
            tree_edge_t want;
            if (edges_due.size() == 0)
            begin
                report("unexpected edge", data, '0);
                return;
            end
            want = edges_due.pop_front();
            edges_checked++;
            if (data[0 +: IDX_W] !== want.from_v)
                report("from_vertex", data[0 +: IDX_W], want.from_v);
            if (data[TO_LSB +: IDX_W] !== want.to_v)
                report("to_vertex", data[TO_LSB +: IDX_W], want.to_v);
            if (data[WT_LSB +: WFIELD_W] !== want.wt)
                report("edge_weight", data[WT_LSB +: WFIELD_W], want.wt);
            if (data[SUM_LSB +: SUM_W] !== want.total)
                report("total_weight", data[SUM_LSB +: SUM_W], want.total);
            if (data[M_DATA_W-1:PAD_LSB] !== '0)
                report("tdata padding", data[M_DATA_W-1:PAD_LSB], '0);
            if (disc !== want.disc)
                report("disconnected", disc, want.disc);
            if (tail !== want.tail)
                report("last", tail, want.tail);
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    span_tree_check tree_chk;
    bit             written [MAX_VERTICES_DEF][MAX_VERTICES_DEF];
    int             cur_n;
    int             tx_idle_pct;
    int             rx_idle_pct;
    bit             hold_go;
    int             loads_sent;
    int             starts_sent;
    int             quiet = 0;

    prim_minimum_spanning_tree u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            tree_chk.note_item(op_t'(s_tuser), s_tdata[0 +: IDX_W], s_tdata[IDX_W +: IDX_W],
                               s_tdata[2 * IDX_W +: WFIELD_W]);
        if (rst_n && m_tvalid && m_tready)
            tree_chk.check_edge(m_tdata, m_tuser, m_tlast);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_MAX)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d edges still due",
                     quiet, tree_chk.edges_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : sink
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !held)
            begin
                held      = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [WFIELD_W-1:0] rand_weight();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
            return '0;
        if (pick < 50)
            return WFIELD_W'($urandom_range(4, 1));
        if (pick < 58)
            return '1;
        return WFIELD_W'($urandom);
    endfunction

    task automatic send_item(op_t op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                             logic [WFIELD_W-1:0] wt);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {wt, col, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == OP_LOAD)
        begin
            written[row][col] = 1'b1;
            loads_sent++;
        end
        else
            starts_sent++;
    endtask

    // every off-diagonal entry a run may read must hold a weight first
    task automatic start_run(bit zero_fill);
        for (int r = 0; r < cur_n; r++)
        begin
            for (int c = 0; c < cur_n; c++)
            begin
                if (r != c && !written[r][c])
                    send_item(OP_LOAD, IDX_W'(r), IDX_W'(c), zero_fill ? '0 : rand_weight());
            end
        end
        send_item(OP_START, IDX_W'($urandom), IDX_W'($urandom), WFIELD_W'($urandom));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tree_chk.edges_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_count(logic [VC_W-1:0] v);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VC_ADDR;
        pwdata  <= APB_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tree_chk.vcount = v;
        cur_n = (v < 2) ? 2 : ((v > VERTEX_CAP) ? VERTEX_CAP : int'(v));
    endtask

    initial
    begin : stimulus
        logic [VC_W-1:0] vc;
        int              k;
        int              r;
        int              c;
        int              phase;
        int              done;
        bit              hold_now;
        tree_chk = new();
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        tx_idle_pct = 11;
        rx_idle_pct = 45;
        hold_go     = 1'b0;
        cur_n       = VERTEX_CAP;
        loads_sent  = 0;
        starts_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two vertices: heaviest edge, then no edge at all
        set_count(VC_W'(2));
        send_item(OP_LOAD, IDX_W'(0), IDX_W'(1), '1);
        start_run(1'b1);
        send_item(OP_LOAD, IDX_W'(0), IDX_W'(1), '0);
        start_run(1'b1);
        // counts below the minimum act as two
        set_count(VC_W'(0));
        send_item(OP_LOAD, IDX_W'(0), IDX_W'(1), WFIELD_W'(1));
        start_run(1'b1);
        set_count(VC_W'(1));
        send_item(OP_LOAD, IDX_W'(1), IDX_W'(0), WFIELD_W'(7));
        start_run(1'b1);
        // ties on weight and on source, then a tree cut off part way
        set_count(VC_W'(4));
        send_item(OP_LOAD, IDX_W'(0), IDX_W'(1), WFIELD_W'(5));
        send_item(OP_LOAD, IDX_W'(0), IDX_W'(2), WFIELD_W'(5));
        send_item(OP_LOAD, IDX_W'(1), IDX_W'(2), WFIELD_W'(5));
        send_item(OP_LOAD, IDX_W'(1), IDX_W'(3), WFIELD_W'(3));
        send_item(OP_LOAD, IDX_W'(15), IDX_W'(15), WFIELD_W'(16'hA5A5));
        start_run(1'b1);
        send_item(OP_LOAD, IDX_W'(1), IDX_W'(3), '0);
        start_run(1'b1);
        // full size once so that later large counts find a filled matrix
        set_count(VC_W'(16));
        start_run(1'b0);

        done = 0;
        while (done < RAND_ITEMS)
        begin
            phase = done * 3 / RAND_ITEMS;
            tx_idle_pct = (phase == 0) ? 11 : ((phase == 1) ? 45 : 0);
            rx_idle_pct = (phase == 0) ? 45 : ((phase == 1) ? 11 : 0);
            if ($urandom_range(1) == 0)
            begin
                k = $urandom_range(99);
                if (k < 70)
                    vc = VC_W'($urandom_range(6, 2));
                else if (k < 85)
                    vc = VC_W'($urandom_range(12, 7));
                else if (k < 92)
                    vc = VC_W'(16);
                else if ($urandom_range(1) == 0)
                    vc = VC_W'($urandom_range(1, 0));
                else
                    vc = VC_W'($urandom_range(31, 17));
                set_count(vc);
            end
            k = $urandom_range(2 * cur_n, 1);
            repeat (k)
            begin
                if ($urandom_range(99) < 85)
                begin
                    r = $urandom_range(cur_n - 1);
                    c = $urandom_range(cur_n - 1);
                end
                else
                begin
                    r = $urandom_range(MAX_VERTICES_DEF - 1);
                    c = $urandom_range(MAX_VERTICES_DEF - 1);
                end
                send_item(OP_LOAD, IDX_W'(r), IDX_W'(c), rand_weight());
                done++;
            end
            // output held off while a run and further items keep coming
            hold_now = (phase == 1 && !hold_go && done > RAND_ITEMS / 2);
            if (hold_now)
                hold_go = 1'b1;
            start_run(1'b0);
            done++;
            if (hold_now || $urandom_range(2) == 0)
            begin
                send_item(OP_START, IDX_W'($urandom), IDX_W'($urandom), WFIELD_W'($urandom));
                done++;
            end
        end

        wait_idle();
        $display("ran %0d weight loads and %0d tree runs (%0d cut off before spanning)",
                 loads_sent, starts_sent, tree_chk.disc_runs);
        $display("compared %0d emitted edges, %0d mismatches",
                 tree_chk.edges_checked, tree_chk.mismatches);
        if (tree_chk.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
hw/rtl/pmst_pkg.sv
hw/rtl/pmst_ctrl.sv
hw/rtl/pmst_dpath.sv
hw/rtl/prim_minimum_spanning_tree.sv
dv/tb.sv
